@@ hdl/scancode_to_ascii_key_fifo_top_macros.svh @@
// ----------------------------------------------------------------------------
// Scan code to ASCII key FIFO: assertion macros
// Concurrent checks sampled on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_KEY_FIFO_TOP_MACROS_SVH
`define SCANCODE_TO_ASCII_KEY_FIFO_TOP_MACROS_SVH

`ifndef SYNTHESIS

// cond and prop hold in the same cycle
`define SC2A_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sc2a check failed");

// prop holds in the cycle after cond
`define SC2A_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sc2a check failed");

`else

`define SC2A_ASSERT_SAME(label, cond, prop)
`define SC2A_ASSERT_NEXT(label, cond, prop)

`endif

`endif

@@ hdl/sc2a_pkg.sv @@
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, scan codes and key maps shared by the scan code to ASCII FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sc2a_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int CHAR_W         = 7;

  // scan code set 1 make codes
  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CTRL     = 7'h1D;
  localparam logic [6:0] SC_CAPS     = 7'h3A;
  localparam logic [6:0] KEY_MAP_LEN = 7'd58;

  // letter key code ranges
  localparam logic [6:0] SC_ROW1_LO = 7'h10;
  localparam logic [6:0] SC_ROW1_HI = 7'h19;
  localparam logic [6:0] SC_ROW2_LO = 7'h1E;
  localparam logic [6:0] SC_ROW2_HI = 7'h26;
  localparam logic [6:0] SC_ROW3_LO = 7'h2C;
  localparam logic [6:0] SC_ROW3_HI = 7'h32;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5A;

  // translator result for one scan byte
  typedef struct packed {
    logic              push;
    logic [CHAR_W-1:0] ch;
  } xlate_t;

  function automatic logic [CHAR_W-1:0] lower_map(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      6'd1:  c = 7'h1B;
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h71;
      6'd17: c = 7'h77;
      6'd18: c = 7'h65;
      6'd19: c = 7'h72;
      6'd20: c = 7'h74;
      6'd21: c = 7'h79;
      6'd22: c = 7'h75;
      6'd23: c = 7'h69;
      6'd24: c = 7'h6F;
      6'd25: c = 7'h70;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;
      6'd31: c = 7'h73;
      6'd32: c = 7'h64;
      6'd33: c = 7'h66;
      6'd34: c = 7'h67;
      6'd35: c = 7'h68;
      6'd36: c = 7'h6A;
      6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;
      6'd45: c = 7'h78;
      6'd46: c = 7'h63;
      6'd47: c = 7'h76;
      6'd48: c = 7'h62;
      6'd49: c = 7'h6E;
      6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] upper_map(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      6'd1:  c = 7'h1B;
      6'd2:  c = 7'h21;
      6'd3:  c = 7'h40;
      6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;
      6'd7:  c = 7'h5E;
      6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;
      6'd11: c = 7'h29;
      6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h51;
      6'd17: c = 7'h57;
      6'd18: c = 7'h45;
      6'd19: c = 7'h52;
      6'd20: c = 7'h54;
      6'd21: c = 7'h59;
      6'd22: c = 7'h55;
      6'd23: c = 7'h49;
      6'd24: c = 7'h4F;
      6'd25: c = 7'h50;
      6'd26: c = 7'h7B;
      6'd27: c = 7'h7D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h41;
      6'd31: c = 7'h53;
      6'd32: c = 7'h44;
      6'd33: c = 7'h46;
      6'd34: c = 7'h47;
      6'd35: c = 7'h48;
      6'd36: c = 7'h4A;
      6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;
      6'd39: c = 7'h3A;
      6'd40: c = 7'h22;
      6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;
      6'd44: c = 7'h5A;
      6'd45: c = 7'h58;
      6'd46: c = 7'h43;
      6'd47: c = 7'h56;
      6'd48: c = 7'h42;
      6'd49: c = 7'h4E;
      6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;
      6'd53: c = 7'h3F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sc2a_ram.sv @@
// ----------------------------------------------------------------------------
// sc2a_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/sc2a_xlate.sv @@
// ----------------------------------------------------------------------------
// sc2a_xlate
// Modifier tracking and scan code set 1 to ASCII translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sc2a_xlate
  import sc2a_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [7:0] scancode,
  output xlate_t          xl
);

  logic shift_held;
  logic ctrl_held;
  logic caps_on;

  logic              rel;
  logic [6:0]        code;
  logic              is_shift;
  logic              is_ctrl;
  logic              is_caps;
  logic              in_map;
  logic              is_letter;
  logic              upper;
  logic [CHAR_W-1:0] base;
  logic              ctrl_letter;
  logic [CHAR_W-1:0] ch;

  assign rel      = scancode[7];
  assign code     = scancode[6:0];
  assign is_shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);
  assign is_ctrl  = (code == SC_CTRL);
  assign is_caps  = (code == SC_CAPS);
  assign in_map   = (code < KEY_MAP_LEN);

  assign is_letter = ((code >= SC_ROW1_LO) && (code <= SC_ROW1_HI)) ||
                     ((code >= SC_ROW2_LO) && (code <= SC_ROW2_HI)) ||
                     ((code >= SC_ROW3_LO) && (code <= SC_ROW3_HI));

  // caps lock inverts the shift choice only for letter keys
  assign upper = shift_held ^ (is_letter && caps_on);
  assign base  = upper ? upper_map(code[5:0]) : lower_map(code[5:0]);

  assign ctrl_letter = ctrl_held &&
                       (((base >= CH_LOWER_A) && (base <= CH_LOWER_Z)) ||
                        ((base >= CH_UPPER_A) && (base <= CH_UPPER_Z)));

  // ctrl+letter: low five bits give 1..26 for either case
  assign ch = ctrl_letter ? {2'b00, base[4:0]} : base;

  assign xl.ch   = ch;
  assign xl.push = !rel && !is_shift && !is_ctrl && !is_caps && in_map &&
                   (ch != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
      caps_on    <= 1'b0;
    end else if (en) begin
      if (rel) begin
        if (is_shift) begin
          shift_held <= 1'b0;
        end
        if (is_ctrl) begin
          ctrl_held <= 1'b0;
        end
      end else begin
        if (is_shift) begin
          shift_held <= 1'b1;
        end
        if (is_ctrl) begin
          ctrl_held <= 1'b1;
        end
        if (is_caps) begin
          caps_on <= !caps_on;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/scancode_to_ascii_key_fifo_top.sv @@
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_fifo_top
// Scan code set 1 keyboard translator feeding a character ring FIFO.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall is low: a scan code byte (kind 0)
// or a pop (kind 1), and gives one result beat per input beat, in order. The
// translated character is written into the FIFO RAM in the accept cycle, and
// a pop reads the RAM through its registered read port, so the result sits in
// the read stage and then moves to the output register. The single read and
// single write port of the RAM set the one-beat-per-cycle rate. The FIFO holds
// up to FIFO_DEPTH-1 characters; a character pushed into a full FIFO is lost
// and flagged with dropped. The RAM needs no clearing after reset and the
// block accepts beats right away.
`timescale 1ns / 1ps
`default_nettype none

`include "scancode_to_ascii_key_fifo_top_macros.svh"

module scancode_to_ascii_key_fifo_top
  import sc2a_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [7:0]        scancode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] char_out,
  output logic                   char_valid,
  output logic                   key_available,
  output logic                   dropped
);

  localparam int AW = $clog2(FIFO_DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  xlate_t xl;

  logic [AW-1:0] rptr;
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr_next;
  logic [AW-1:0] wptr_next;
  logic [AW-1:0] wptr_inc;

  logic in_fire;
  logic scan_fire;
  logic pop_fire;
  logic full;
  logic empty;
  logic push_do;
  logic drop_do;
  logic pop_do;

  logic [CHAR_W-1:0] rdata;

  // read stage: RAM data plus the result flags of the same beat
  logic s1_valid;
  logic s1_hit;
  logic s1_avail;
  logic s1_drop;
  logic s1_adv;

  assign in_fire   = in_valid && !in_stall;
  assign scan_fire = in_fire && !kind;
  assign pop_fire  = in_fire && kind;

  sc2a_xlate u_xlate (
    .clk      (clk),
    .rst      (rst),
    .en       (scan_fire),
    .scancode (scancode),
    .xl       (xl)
  );

  assign wptr_inc = ring_next(wptr);
  assign full     = (wptr_inc == rptr);
  assign empty    = (wptr == rptr);
  assign push_do  = scan_fire && xl.push && !full;
  assign drop_do  = scan_fire && xl.push && full;
  assign pop_do   = pop_fire && !empty;

  assign wptr_next = push_do ? wptr_inc : wptr;
  assign rptr_next = pop_do ? ring_next(rptr) : rptr;

  sc2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_do),
    .waddr (wptr),
    .wdata (xl.ch),
    .re    (pop_do),
    .raddr (rptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= '0;
      wptr <= '0;
    end else begin
      rptr <= rptr_next;
      wptr <= wptr_next;
    end
  end

  // RAM read data holds while the read stage waits, since no new pop fires
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hit   <= pop_do;
      s1_avail <= (rptr_next != wptr_next);
      s1_drop  <= drop_do;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      char_out      <= s1_hit ? rdata : '0;
      char_valid    <= s1_hit;
      key_available <= s1_avail;
      dropped       <= s1_drop;
    end
  end

  `SC2A_ASSERT_SAME(a_no_overfill, push_do, wptr_inc != rptr)
  `SC2A_ASSERT_NEXT(a_fire_reaches_s1, in_fire, s1_valid)
  `SC2A_ASSERT_SAME(a_pop_char_nonzero, out_valid && char_valid, char_out != '0 && !dropped)
  `SC2A_ASSERT_SAME(a_no_char_is_zero, out_valid && !char_valid, char_out == '0)

endmodule

`default_nettype wire
